FILE: rtl/core/text_layer_lexical_preflight_assert.svh
// Assertion macros for the lexical preflight block.
`ifndef TEXT_LAYER_LEXICAL_PREFLIGHT_ASSERT_SVH
`define TEXT_LAYER_LEXICAL_PREFLIGHT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define TLP_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Implication checked in the cycle after the precondition.
`define TLP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/tlp_pkg.sv
package tlp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);

	localparam int FB_W = 25;
	localparam int TK_W = 19;
	localparam int TL_W = 13;
	localparam int CFG_W = 25;

	localparam logic [1:0] CFG_MAX_FILE = 2'd0;
	localparam logic [1:0] CFG_MAX_TOK = 2'd1;
	localparam logic [1:0] CFG_MAX_TLEN = 2'd2;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_SIZE = 4'd1,
		ST_UTF8 = 4'd2,
		ST_HEADER = 4'd3,
		ST_TOKENS = 4'd4,
		ST_STR_LONG = 4'd5,
		ST_UNTERM = 4'd6,
		ST_DEEP = 4'd7,
		ST_UNBAL = 4'd8,
		ST_WORD_LONG = 4'd9,
		ST_UNCLOSED = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		M_TOP = 3'd0,
		M_COMMENT = 3'd1,
		M_WORD = 3'd2,
		M_OPEN1 = 3'd3,
		M_OPEN2 = 3'd4,
		M_STR = 3'd5,
		M_HALT = 3'd6
	} lex_mode_t;

	typedef enum logic [1:0] {
		BR_CURLY = 2'd1,
		BR_SQUARE = 2'd2,
		BR_ROUND = 2'd3
	} bracket_t;

	typedef struct packed {
		logic [FB_W-1:0] max_file_bytes;
		logic [TK_W-1:0] max_tokens;
		logic [TL_W-1:0] max_token_bytes;
	} cfg_t;

	// Stack operation requested by the lexer for the current beat.
	typedef struct packed {
		logic push;
		logic pop;
		logic [1:0] kind;
	} stack_op_t;

	typedef struct packed {
		logic [3:0] status;
		logic [TK_W-1:0] token_count;
	} result_t;

	localparam logic [7:0] HDR_TEXT [9] = '{8'h23, 8'h75, 8'h73, 8'h64, 8'h61,
		8'h20, 8'h31, 8'h2E, 8'h30};

	function automatic logic is_ws(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		case (b)
			8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h2C, 8'h3D, 8'h3A, 8'h3B,
			8'h22, 8'h27, 8'h40, 8'h23: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] rank_min(input logic [3:0] cur, input logic [3:0] code);
		return (cur == ST_OK || code < cur) ? code : cur;
	endfunction

endpackage

FILE: rtl/core/tlp_stream_if.sv
interface tlp_stream_if #(parameter int W = 9);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/tlp_precheck.sv
// Byte budget, UTF-8 decoder and header match.
module tlp_precheck (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic clr,
	input logic [7:0] b,
	input logic [tlp_pkg::FB_W-1:0] max_file_bytes,
	output logic [3:0] err_final
);
	import tlp_pkg::*;

	logic [FB_W-1:0] bytes_q, bytes_d;
	logic [1:0] u_prog_q, u_prog_d;
	logic [2:0] u_cls_q, u_cls_d;
	logic [3:0] h_prog_q, h_prog_d;
	logic [3:0] err_q, err_d;
	logic [7:0] lo, hi;

	always_comb begin
		bytes_d = bytes_q;
		u_prog_d = u_prog_q;
		u_cls_d = u_cls_q;
		h_prog_d = h_prog_q;
		err_d = err_q;
		lo = 8'h80;
		hi = 8'hBF;
		if (bytes_q != {FB_W{1'b1}})
			bytes_d = bytes_q + 1'b1;
		if (bytes_d > max_file_bytes)
			err_d = rank_min(err_d, ST_SIZE);
		if (u_prog_q == 2'd0) begin
			u_cls_d = 3'd0;
			if (b == 8'h00) err_d = rank_min(err_d, ST_UTF8);
			else if (b < 8'h80) begin
			end else if (b >= 8'hC2 && b <= 8'hDF) u_prog_d = 2'd1;
			else if (b == 8'hE0) begin u_prog_d = 2'd2; u_cls_d = 3'd1; end
			else if (b == 8'hED) begin u_prog_d = 2'd2; u_cls_d = 3'd2; end
			else if (b >= 8'hE1 && b <= 8'hEF) u_prog_d = 2'd2;
			else if (b == 8'hF0) begin u_prog_d = 2'd3; u_cls_d = 3'd3; end
			else if (b >= 8'hF1 && b <= 8'hF3) u_prog_d = 2'd3;
			else if (b == 8'hF4) begin u_prog_d = 2'd3; u_cls_d = 3'd4; end
			else err_d = rank_min(err_d, ST_UTF8);
		end else begin
			case (u_cls_q)
				3'd1: lo = 8'hA0;
				3'd2: hi = 8'h9F;
				3'd3: lo = 8'h90;
				3'd4: hi = 8'h8F;
				default: ;
			endcase
			u_cls_d = 3'd0;
			if (b >= lo && b <= hi) u_prog_d = u_prog_q - 1'b1;
			else begin
				err_d = rank_min(err_d, ST_UTF8);
				u_prog_d = 2'd0;
			end
		end
		if (h_prog_q < 4'd9) begin
			if (h_prog_q == 4'd0 && (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A)) begin
			end else if (b == HDR_TEXT[h_prog_q]) h_prog_d = h_prog_q + 1'b1;
			else begin
				h_prog_d = 4'd10;
				err_d = rank_min(err_d, ST_HEADER);
			end
		end
		err_final = err_d;
		if (u_prog_d != 2'd0) err_final = rank_min(err_final, ST_UTF8);
		if (h_prog_d < 4'd9) err_final = rank_min(err_final, ST_HEADER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			u_prog_q <= '0;
			u_cls_q <= '0;
			h_prog_q <= '0;
			err_q <= ST_OK;
		end else if (step) begin
			if (clr) begin
				bytes_q <= '0;
				u_prog_q <= '0;
				u_cls_q <= '0;
				h_prog_q <= '0;
				err_q <= ST_OK;
			end else begin
				bytes_q <= bytes_d;
				u_prog_q <= u_prog_d;
				u_cls_q <= u_cls_d;
				h_prog_q <= h_prog_d;
				err_q <= err_d;
			end
		end
	end
endmodule

FILE: rtl/core/tlp_lexer.sv
// Lexical pass: tokens, strings, words and bracket stack.
module tlp_lexer (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic clr,
	input logic [7:0] b,
	input tlp_pkg::cfg_t cfg,
	output logic [3:0] err_final,
	output logic [tlp_pkg::TK_W-1:0] tok_count
);
	import tlp_pkg::*;

	lex_mode_t mode_q, mode_d;
	logic [1:0] qk_q, qk_d;
	logic tri_q, tri_d;
	logic [1:0] run_q, run_d;
	logic esc_q, esc_d;
	logic [TL_W-1:0] len_q, len_d;
	logic [LVL_W-1:0] lvl_q, lvl_d;
	logic [TK_W-1:0] tok_q, tok_d;
	logic [3:0] err_q, err_d;
	logic [1:0] stk_q [STACK_DEPTH];
	logic [1:0] top_kind;
	stack_op_t op;
	logic [7:0] q;
	logic top_go, str_go;
	logic [TL_W-1:0] len_m1;

	assign top_kind = (lvl_q != '0) ? stk_q[SP_W'(lvl_q - 1'b1)] : 2'd0;
	assign q = (qk_q == 2'd1) ? 8'h22 : (qk_q == 2'd2) ? 8'h27 : 8'h40;

	always_comb begin
		mode_d = mode_q;
		qk_d = qk_q;
		tri_d = tri_q;
		run_d = run_q;
		esc_d = esc_q;
		len_d = len_q;
		lvl_d = lvl_q;
		tok_d = tok_q;
		err_d = err_q;
		op = '0;
		top_go = 1'b0;
		str_go = 1'b0;
		len_m1 = '0;
		unique case (mode_q)
			M_TOP: top_go = 1'b1;
			M_COMMENT: if (b == 8'h0A) mode_d = M_TOP;
			M_WORD: begin
				if (is_ws(b) || is_delim(b)) begin
					mode_d = M_TOP;
					top_go = 1'b1;
				end else begin
					if (len_q != {TL_W{1'b1}}) len_d = len_q + 1'b1;
					if (len_d >= cfg.max_token_bytes) begin
						if (err_d == ST_OK) err_d = ST_WORD_LONG;
						mode_d = M_HALT;
					end
				end
			end
			M_OPEN1: begin
				if (b == q) mode_d = M_OPEN2;
				else begin
					mode_d = M_STR;
					tri_d = 1'b0;
					len_d = '0;
					str_go = 1'b1;
				end
			end
			M_OPEN2: begin
				if (b == q) begin
					mode_d = M_STR;
					tri_d = 1'b1;
					len_d = '0;
					run_d = 2'd0;
				end else begin
					mode_d = M_TOP;
					top_go = 1'b1;
				end
			end
			M_STR: begin
				if (esc_q) begin
					esc_d = 1'b0;
					if (len_q != {TL_W{1'b1}}) len_d = len_q + 1'b1;
				end else if (run_q != 2'd0 && b == q) begin
					if (run_q == 2'd2) begin
						run_d = 2'd0;
						mode_d = M_TOP;
					end else begin
						run_d = 2'd2;
						if (len_q != {TL_W{1'b1}}) len_d = len_q + 1'b1;
					end
				end else begin
					run_d = 2'd0;
					str_go = 1'b1;
				end
			end
			M_HALT: ;
			default: ;
		endcase
		if (str_go) begin
			if (len_d > cfg.max_token_bytes) begin
				if (err_d == ST_OK) err_d = ST_STR_LONG;
				mode_d = M_HALT;
			end else if (qk_q != 2'd3 && b == 8'h5C) begin
				esc_d = 1'b1;
				if (len_d != {TL_W{1'b1}}) len_d = len_d + 1'b1;
			end else if (b == q) begin
				if (!tri_d) mode_d = M_TOP;
				else begin
					run_d = 2'd1;
					if (len_d != {TL_W{1'b1}}) len_d = len_d + 1'b1;
				end
			end else if (len_d != {TL_W{1'b1}}) len_d = len_d + 1'b1;
		end
		if (top_go && !is_ws(b)) begin
			if (b == 8'h23) mode_d = M_COMMENT;
			else if (tok_q >= cfg.max_tokens) begin
				if (err_d == ST_OK) err_d = ST_TOKENS;
				mode_d = M_HALT;
			end else begin
				tok_d = tok_q + 1'b1;
				case (b)
					8'h22, 8'h27, 8'h40: begin
						qk_d = (b == 8'h22) ? 2'd1 : (b == 8'h27) ? 2'd2 : 2'd3;
						tri_d = 1'b0;
						run_d = 2'd0;
						esc_d = 1'b0;
						len_d = '0;
						mode_d = M_OPEN1;
					end
					8'h7B, 8'h5B, 8'h28: begin
						if (lvl_q >= LVL_W'(STACK_DEPTH)) begin
							if (err_d == ST_OK) err_d = ST_DEEP;
							mode_d = M_HALT;
						end else begin
							op.push = 1'b1;
							op.kind = (b == 8'h7B) ? BR_CURLY : (b == 8'h5B) ? BR_SQUARE : BR_ROUND;
							lvl_d = lvl_q + 1'b1;
						end
					end
					8'h7D, 8'h5D, 8'h29: begin
						op.kind = (b == 8'h7D) ? BR_CURLY : (b == 8'h5D) ? BR_SQUARE : BR_ROUND;
						if (lvl_q == '0 || top_kind != op.kind) begin
							if (err_d == ST_OK) err_d = ST_UNBAL;
							mode_d = M_HALT;
						end else begin
							op.pop = 1'b1;
							lvl_d = lvl_q - 1'b1;
						end
					end
					8'h2C, 8'h3D, 8'h3A, 8'h3B: ;
					default: begin
						len_d = '0;
						mode_d = M_WORD;
					end
				endcase
			end
		end
		// end-of-file checks on the updated state
		err_final = err_d;
		len_m1 = len_d - 1'b1;
		if (mode_d == M_OPEN1) begin
			if (err_final == ST_OK) err_final = ST_UNTERM;
		end else if (mode_d == M_STR) begin
			if (!esc_d && run_d == 2'd2 && len_m1 > cfg.max_token_bytes) begin
				if (err_final == ST_OK) err_final = ST_STR_LONG;
			end else if (err_final == ST_OK) err_final = ST_UNTERM;
		end
		if (mode_d != M_HALT && mode_d != M_OPEN1 && mode_d != M_STR && lvl_d != '0)
			if (err_final == ST_OK) err_final = ST_UNCLOSED;
		tok_count = (tok_d < cfg.max_tokens) ? tok_d : cfg.max_tokens;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TOP;
			qk_q <= '0;
			tri_q <= 1'b0;
			run_q <= '0;
			esc_q <= 1'b0;
			len_q <= '0;
			lvl_q <= '0;
			tok_q <= '0;
			err_q <= ST_OK;
		end else if (step) begin
			if (clr) begin
				mode_q <= M_TOP;
				qk_q <= '0;
				tri_q <= 1'b0;
				run_q <= '0;
				esc_q <= 1'b0;
				len_q <= '0;
				lvl_q <= '0;
				tok_q <= '0;
				err_q <= ST_OK;
			end else begin
				mode_q <= mode_d;
				qk_q <= qk_d;
				tri_q <= tri_d;
				run_q <= run_d;
				esc_q <= esc_d;
				len_q <= len_d;
				lvl_q <= lvl_d;
				tok_q <= tok_d;
				err_q <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && op.push)
			stk_q[SP_W'(lvl_q)] <= op.kind;
	end
endmodule

FILE: rtl/core/text_layer_lexical_preflight.sv
// channel | dir | payload                 | beat
// in_s    | in  | {last_byte, data_byte}  | one file byte
// out_s   | out | {status, token_count}   | one result at the last byte
// cfg     | in  | cfg_idx, cfg_data       | one register write
// One byte per cycle: each accepted beat updates all checks in the cycle it is accepted.
// The result is registered and valid the cycle after the last byte's beat.
// While a result waits unaccepted the input is held; with out ready the
// input keeps taking a byte every cycle.
// Reset clears all control state; the bracket stack needs no clearing.
module text_layer_lexical_preflight (
	input logic clk,
	input logic arst_n,
	tlp_stream_if.sink in_s,
	tlp_stream_if.source out_s,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [tlp_pkg::CFG_W-1:0] cfg_data
);
	import tlp_pkg::*;

	cfg_t cfg_q;
	logic [7:0] b;
	logic last, step;
	logic [3:0] pre_fin, lex_fin;
	logic [TK_W-1:0] tok;
	logic out_v_q;
	result_t res_q, res_d;

	assign b = in_s.data[7:0];
	assign last = in_s.data[8];
	assign in_s.ready = !out_v_q || out_s.ready;
	assign step = in_s.valid && in_s.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_file_bytes <= FB_W'(16777216);
			cfg_q.max_tokens <= TK_W'(262144);
			cfg_q.max_token_bytes <= TL_W'(4096);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_FILE: cfg_q.max_file_bytes <= cfg_data[FB_W-1:0];
				CFG_MAX_TOK: cfg_q.max_tokens <= cfg_data[TK_W-1:0];
				CFG_MAX_TLEN: cfg_q.max_token_bytes <= cfg_data[TL_W-1:0];
				default: ;
			endcase
		end
	end

	tlp_precheck u_pre (
		.clk, .arst_n, .step, .clr(last), .b,
		.max_file_bytes(cfg_q.max_file_bytes),
		.err_final(pre_fin)
	);

	tlp_lexer u_lex (
		.clk, .arst_n, .step, .clr(last), .b, .cfg(cfg_q),
		.err_final(lex_fin), .tok_count(tok)
	);

	always_comb begin
		res_d.status = (pre_fin != ST_OK) ? pre_fin : lex_fin;
		res_d.token_count = tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (step && last) out_v_q <= 1'b1;
		else if (out_s.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last) res_q <= res_d;
	end

	assign out_s.valid = out_v_q;
	assign out_s.data = res_q;
endmodule

FILE: rtl/core/tlp_checker.sv
module tlp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] out_status
);
	`include "text_layer_lexical_preflight_assert.svh"

	`TLP_ASSERT_IMP(a_status_range, clk, arst_n, out_valid, out_status <= 4'd10)
	`TLP_ASSERT_NEXT(a_last_gives_result, clk, arst_n, in_valid && in_ready && in_last, out_valid)
	`TLP_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`TLP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_status))
endmodule

bind text_layer_lexical_preflight tlp_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_s.valid), .in_ready(in_s.ready), .in_last(in_s.data[8]),
	.out_valid(out_s.valid), .out_ready(out_s.ready), .out_status(out_s.data[22:19])
);
